@@ src/sfpf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_pkg
// Shared types and constants of the Scharr flying-pixel filter.
// ----------------------------------------------------------------------------
package sfpf_pkg;

  localparam int PIX_W      = 16;   // sample width
  localparam int THR_W      = 14;   // grad_threshold
  localparam int WID_W      = 11;   // image_width
  localparam int HGT_W      = 12;   // image_height
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GRAD_W     = 22;   // signed gradient, |g| < 16 * 2^16
  localparam int SQ_W       = 2 * THR_W;

  localparam int WIDTH_RST  = 320;
  localparam int HEIGHT_RST = 240;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // per-item window control, decided when the item is taken
  typedef struct packed {
    logic produce;  // item completes a window, one result follows
    logic last;     // result is the final pixel of the frame
    logic lv;       // left column inside the frame
    logic rv;       // right column inside the frame
    logic tv;       // top row inside the frame
    logic bv;       // bottom row inside the frame
  } win_ctl_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    pix_t                     center;
    logic                     last;
  } grad_t;

endpackage
`default_nettype wire

@@ src/scharr_flying_pixel_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scharr_flying_pixel_filter_unit
// Streaming 3x3 Scharr gradient test that zeroes flying pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raster pixel per transfer, in_tuser = 1 marks a flush item
//           that loads a zero sample. After the frame send image_width + 1
//           flush items; the last of them releases the final pixel.
//   out_* : filtered pixel, out_tlast on the frame's final pixel. A result
//           belongs to the pixel one row plus one pixel before the input
//           transfer that completes its window.
//   cfg_* : register writes (0 threshold, 1 width, 2 height), always ready,
//           to be written while the stream is idle.
// Path of a result: line store read, masked window, gradients, magnitude and squares, output register.
// Throughput: one item per clock while the skid entry is free; each item does one read
//   and one write of the dual-port line RAM (upper and middle rows side by side in one word).
// Reset clears counters, window and registers to their defaults; the line RAM is not
//   cleared, and entries read before the frame writes them feed only masked window cells.
// When the receiver stalls, the output register and one skid entry hold
//   results; in_tready falls only once the skid entry is full.
// ----------------------------------------------------------------------------
module scharr_flying_pixel_filter_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [15:0]                        in_tdata,   // [15:0] pixel_in
  input  wire logic                               in_tuser,   // [0] flush_item
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [15:0]                        out_tdata,  // [15:0] pixel_out
  output logic                                    out_tlast,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sfpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sfpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sfpf_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = ((AW + 1) > WID_W) ? (AW + 1) : WID_W;
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  // configuration, held in the form the datapath uses
  logic [THR_W-1:0] thr_r;
  logic [SQ_W-1:0]  tsq_r;
  logic [WW-1:0]    w_eff_r;
  logic [HGT_W-1:0] h_eff_r;
  logic [THR_W-1:0] cfg_thr;
  logic [WW-1:0]    cfg_w;
  logic [HGT_W-1:0] cfg_h;

  logic             en, accept;
  pix_t             in_pix;
  logic [AW-1:0]    rd_addr;
  win_ctl_t         ctl;
  logic [2*PIX_W-1:0] ram_rd_data, ram_wr_data;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic             grad_valid;
  grad_t            grad;
  logic             res_valid, res_last;
  pix_t             res_pix;

  logic             out_valid_r, skid_valid_r;
  pix_t             out_pix_r, skid_pix_r;
  logic             out_last_r, skid_last_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_thr = cfg_data[THR_W-1:0];
    if (cfg_data[WID_W-1:0] == '0) begin
      cfg_w = WW'(1);
    end else if (WW'(cfg_data[WID_W-1:0]) > WW'(MAX_WIDTH)) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(cfg_data[WID_W-1:0]);
    end
    cfg_h = (cfg_data[HGT_W-1:0] == '0) ? HGT_W'(1) : cfg_data[HGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      tsq_r   <= '0;
      w_eff_r <= WW'(W_RST);
      h_eff_r <= HGT_W'(HEIGHT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAD_THRESHOLD: begin
          thr_r <= cfg_thr;
          tsq_r <= SQ_W'(cfg_thr) * SQ_W'(cfg_thr);
        end
        CFG_IMAGE_WIDTH:  w_eff_r <= cfg_w;
        CFG_IMAGE_HEIGHT: h_eff_r <= cfg_h;
        default: ;
      endcase
    end
  end

  // the whole pipeline moves while the skid entry is free
  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign in_pix    = in_tuser ? '0 : in_tdata;

  sfpf_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .w_eff   (w_eff_r),
    .h_eff   (h_eff_r),
    .rd_addr (rd_addr),
    .ctl     (ctl)
  );

  sfpf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  sfpf_grad #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_grad (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .accept      (accept),
    .rd_addr     (rd_addr),
    .in_pix      (in_pix),
    .ctl_in      (ctl),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .grad_valid  (grad_valid),
    .grad        (grad)
  );

  sfpf_mag u_mag (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .grad_valid (grad_valid),
    .grad       (grad),
    .thr        (thr_r),
    .tsq        (tsq_r),
    .res_valid  (res_valid),
    .res_pix    (res_pix),
    .res_last   (res_last)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_pix_r  <= skid_pix_r;
        out_last_r <= skid_last_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_pix_r  <= res_pix;
        skid_last_r <= res_last;
      end else begin
        out_pix_r  <= res_pix;
        out_last_r <= res_last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

@@ src/sfpf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ src/sfpf_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_scan
// Raster position counters: line store address, window borders, frame end.
// ----------------------------------------------------------------------------
module sfpf_scan #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  accept,
  input  wire logic [((($clog2(MAX_WIDTH)+1) > sfpf_pkg::WID_W) ?
                      ($clog2(MAX_WIDTH)+1) : sfpf_pkg::WID_W)-1:0] w_eff,
  input  wire logic [sfpf_pkg::HGT_W-1:0]            h_eff,
  output logic      [$clog2(MAX_WIDTH)-1:0]          rd_addr,
  output sfpf_pkg::win_ctl_t                         ctl
);
  import sfpf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ((AW + 1) > WID_W) ? (AW + 1) : WID_W;
  localparam logic [1:0] ROW_SAT = 2'd2;   // rows seen, saturating at two

  logic [AW-1:0]    col_r, col_nxt;
  logic [1:0]       row_r, row_nxt;
  logic [AW-1:0]    ocol_r, ocol_nxt;
  logic [HGT_W-1:0] orow_r, orow_nxt;

  logic [AW-1:0]  c;
  logic [WW-1:0]  c_inc;
  logic [WW-1:0]  oc_inc;
  logic [HGT_W:0] or_inc;
  logic           col_end, ocol_end, orow_end, produce, last;

  always_comb begin
    // a column count left past a narrowed width wraps to zero
    c        = (WW'(col_r) >= w_eff) ? '0 : col_r;
    c_inc    = WW'(c) + WW'(1);
    col_end  = c_inc >= w_eff;
    produce  = (row_r == ROW_SAT) || ((row_r == 2'd1) && (c != '0));
    oc_inc   = WW'(ocol_r) + WW'(1);
    ocol_end = oc_inc >= w_eff;
    or_inc   = {1'b0, orow_r} + {{HGT_W{1'b0}}, 1'b1};
    orow_end = or_inc >= {1'b0, h_eff};
    last     = produce && ocol_end && orow_end;

    ctl.produce = produce;
    ctl.last    = last;
    ctl.lv      = ocol_r != '0;
    ctl.rv      = !ocol_end;
    ctl.tv      = orow_r != '0;
    ctl.bv      = !orow_end;
    rd_addr     = c;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (accept) begin
      col_nxt = col_end ? '0 : c_inc[AW-1:0];
      if (col_end && (row_r != ROW_SAT)) begin
        row_nxt = row_r + 2'd1;
      end
      if (produce) begin
        if (last) begin
          col_nxt  = '0;
          row_nxt  = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else if (ocol_end) begin
          ocol_nxt = '0;
          orow_nxt = or_inc[HGT_W-1:0];
        end else begin
          ocol_nxt = oc_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/sfpf_grad.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_grad
// Line store write-back, 3x3 window and Scharr gradient stages.
// ----------------------------------------------------------------------------
module sfpf_grad #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             accept,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  input  wire sfpf_pkg::pix_t                   in_pix,
  input  wire sfpf_pkg::win_ctl_t               ctl_in,
  input  wire logic [2*sfpf_pkg::PIX_W-1:0]     ram_rd_data,
  output logic                                  ram_wr_en,
  output logic      [$clog2(MAX_WIDTH)-1:0]     ram_wr_addr,
  output logic      [2*sfpf_pkg::PIX_W-1:0]     ram_wr_data,
  output logic                                  grad_valid,
  output sfpf_pkg::grad_t                       grad
);
  import sfpf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // weights 3, 10, 3 as shifts and adds
  function automatic logic signed [GRAD_W-1:0] scharr_sum(
    input logic signed [GRAD_W-1:0] a,
    input logic signed [GRAD_W-1:0] b,
    input logic signed [GRAD_W-1:0] d
  );
    scharr_sum = (a <<< 1) + a + (b <<< 3) + (b <<< 1) + (d <<< 1) + d;
  endfunction

  // stage 1: line store data returns
  logic                  s1_valid_r;
  logic [AW-1:0]         s1_addr_r;
  pix_t                  s1_pix_r;
  win_ctl_t              s1_ctl_r;
  logic                  fwd_hit_r;
  logic [2*PIX_W-1:0]    fwd_data_r;

  logic [2*PIX_W-1:0]    line;
  pix_t                  top, mid;
  pix_t                  win_r   [9];
  pix_t                  win_nxt [9];
  logic [8:0]            ok;

  // stage 2: masked window
  logic                  s2_valid_r;
  pix_t                  s2_p_r [9];
  pix_t                  s2_center_r;
  logic                  s2_last_r;

  // stage 3: gradients
  logic                  g_valid_r;
  grad_t                 g_r;
  logic signed [GRAD_W-1:0] e [9];

  // same-cycle write and read of one entry: take the write data
  always_comb begin
    line = fwd_hit_r ? fwd_data_r : ram_rd_data;
    top  = line[2*PIX_W-1:PIX_W];
    mid  = line[PIX_W-1:0];
  end

  assign ram_wr_en   = en && s1_valid_r;
  assign ram_wr_addr = s1_addr_r;
  assign ram_wr_data = {mid, s1_pix_r};

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
    ok[0] = s1_ctl_r.tv && s1_ctl_r.lv;
    ok[1] = s1_ctl_r.tv;
    ok[2] = s1_ctl_r.tv && s1_ctl_r.rv;
    ok[3] = s1_ctl_r.lv;
    ok[4] = 1'b1;
    ok[5] = s1_ctl_r.rv;
    ok[6] = s1_ctl_r.bv && s1_ctl_r.lv;
    ok[7] = s1_ctl_r.bv;
    ok[8] = s1_ctl_r.bv && s1_ctl_r.rv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      g_valid_r  <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (en) begin
      s1_valid_r <= accept;
      if (accept) begin
        fwd_hit_r <= s1_valid_r && (rd_addr == s1_addr_r);
      end
      if (s1_valid_r) begin
        for (int k = 0; k < 9; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
      s2_valid_r <= s1_valid_r && s1_ctl_r.produce;
      g_valid_r  <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (accept) begin
        s1_addr_r  <= rd_addr;
        s1_pix_r   <= in_pix;
        s1_ctl_r   <= ctl_in;
        fwd_data_r <= {mid, s1_pix_r};
      end
      for (int k = 0; k < 9; k++) begin
        s2_p_r[k] <= ok[k] ? win_nxt[k] : '0;
      end
      s2_center_r <= win_nxt[4];
      s2_last_r   <= s1_ctl_r.last;
      g_r.gx      <= scharr_sum(e[2] - e[0], e[5] - e[3], e[8] - e[6]);
      g_r.gy      <= scharr_sum(e[6] - e[0], e[7] - e[1], e[8] - e[2]);
      g_r.center  <= s2_center_r;
      g_r.last    <= s2_last_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = $signed({{(GRAD_W - PIX_W){1'b0}}, s2_p_r[k]});
    end
  end

  assign grad_valid = g_valid_r;
  assign grad       = g_r;

endmodule
`default_nettype wire

@@ src/sfpf_mag.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_mag
// Gradient magnitude test against the threshold, squares on narrow values.
// ----------------------------------------------------------------------------
module sfpf_mag (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         grad_valid,
  input  wire sfpf_pkg::grad_t              grad,
  input  wire logic [sfpf_pkg::THR_W-1:0]   thr,
  input  wire logic [sfpf_pkg::SQ_W-1:0]    tsq,
  output logic                              res_valid,
  output sfpf_pkg::pix_t                    res_pix,
  output logic                              res_last
);
  import sfpf_pkg::*;

  logic [GRAD_W-1:0] ax, ay;
  logic              rej;

  logic              s4_valid_r;
  logic              s4_rej_r;
  logic [THR_W-1:0]  s4_ax_r, s4_ay_r;
  pix_t              s4_center_r;
  logic              s4_last_r;

  logic              s5_valid_r;
  logic              s5_rej_r;
  logic [SQ_W-1:0]   s5_sqx_r, s5_sqy_r;
  pix_t              s5_center_r;
  logic              s5_last_r;

  logic [SQ_W:0]     sq_sum;

  // once both magnitudes are below the threshold they fit its width
  always_comb begin
    ax  = grad.gx[GRAD_W-1] ? $unsigned(-grad.gx) : $unsigned(grad.gx);
    ay  = grad.gy[GRAD_W-1] ? $unsigned(-grad.gy) : $unsigned(grad.gy);
    rej = (ax >= GRAD_W'(thr)) || (ay >= GRAD_W'(thr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= grad_valid;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rej_r    <= rej;
      s4_ax_r     <= ax[THR_W-1:0];
      s4_ay_r     <= ay[THR_W-1:0];
      s4_center_r <= grad.center;
      s4_last_r   <= grad.last;
      s5_rej_r    <= s4_rej_r;
      s5_sqx_r    <= SQ_W'(s4_ax_r) * SQ_W'(s4_ax_r);
      s5_sqy_r    <= SQ_W'(s4_ay_r) * SQ_W'(s4_ay_r);
      s5_center_r <= s4_center_r;
      s5_last_r   <= s4_last_r;
    end
  end

  always_comb begin
    sq_sum = {1'b0, s5_sqx_r} + {1'b0, s5_sqy_r};
    res_pix = (s5_rej_r || (sq_sum >= {1'b0, tsq})) ? '0 : s5_center_r;
  end

  assign res_valid = s5_valid_r;
  assign res_last  = s5_last_r;

endmodule
`default_nettype wire

@@ src/sfpf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfpf_checker
// Port-level checks of the flying-pixel filter, bound to the top level.
// ----------------------------------------------------------------------------
module sfpf_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [15:0]                      out_tdata,
  input wire logic                             out_tlast,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [sfpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [sfpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfpf_pkg::*;

  // tracks whether the threshold register holds zero
  logic thr_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_zero_r <= 1'b1;
    end else if (cfg_valid && cfg_ready && (cfg_index == CFG_GRAD_THRESHOLD)) begin
      thr_zero_r <= cfg_data[THR_W-1:0] == '0;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) && $past(rst_n) |-> $past(out_tready))
    else $error("result withdrawn without transfer");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_thr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && thr_zero_r |-> out_tdata == '0)
    else $error("nonzero pixel with zero threshold");

endmodule

bind scharr_flying_pixel_filter_unit sfpf_checker u_sfpf_checker (.*);
`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Scharr flying-pixel filter. Frames of pixels
// with trailing flush items are streamed in under random valid and ready
// gaps. A behavioral copy of the 3x3 gradient test predicts each filtered
// pixel, and every output transfer is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sfpf_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;     // pipeline depth plus margin

  typedef struct packed {
    pix_t pixel;
    logic is_last;
  } filtered_t;

  typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_DIM, PIX_EXTREME} pix_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;    // [15:0] pixel_in
  logic                  in_tuser;    // [0] flush_item
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;   // [15:0] pixel_out
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scharr_flying_pixel_filter_unit #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // filter state mirror
  logic [THR_W-1:0] thr_cfg;
  logic [WID_W-1:0] width_cfg;
  logic [HGT_W-1:0] height_cfg;
  pix_t             above_line  [MAX_W];
  pix_t             center_line [MAX_W];
  pix_t             window_px   [9];     // row*3 + col, row 0 on top
  int unsigned      in_col, in_row, out_col, out_row;

  filtered_t   filtered_q [$];
  int unsigned items_sent;
  int          n_errors;
  int          quiet_cycles;
  bit          tx_calm, rx_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (width_cfg == 0) return 1;
    if (width_cfg > MAX_W) return MAX_W;
    return width_cfg;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 10000;
      2: return 16383;
      3, 4: return $urandom_range(1, 400);
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  // one accepted item through the window; queues the filtered pixel it releases
  function automatic void compute_filter_step(input pix_t px, input logic flush);
    int unsigned w, h, c, r, k;
    pix_t        v, top, mid;
    logic        produce, ok;
    longint      p [9];
    longint      gx, gy, ax, ay, t;
    filtered_t   res;
    w = eff_width();
    h = (height_cfg == 0) ? 1 : height_cfg;
    if (in_col >= w) in_col = 0;
    c = in_col;
    v = flush ? '0 : px;
    top = above_line[c];
    mid = center_line[c];
    above_line[c]  = mid;
    center_line[c] = v;
    for (k = 0; k < 3; k++) begin
      window_px[k*3]   = window_px[k*3+1];
      window_px[k*3+1] = window_px[k*3+2];
    end
    window_px[2] = top;
    window_px[5] = mid;
    window_px[8] = v;
    produce = (in_row >= 2) || (in_row == 1 && c >= 1);
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!produce) return;

    c = out_col;
    r = out_row;
    for (k = 0; k < 9; k++) begin
      ok = !((k % 3 == 0 && c == 0) || (k % 3 == 2 && c + 1 >= w) ||
             (k / 3 == 0 && r == 0) || (k / 3 == 2 && r + 1 >= h));
      p[k] = ok ? longint'(window_px[k]) : 0;
    end
    gx = 3 * (p[2] - p[0]) + 10 * (p[5] - p[3]) + 3 * (p[8] - p[6]);
    gy = 3 * (p[6] - p[0]) + 10 * (p[7] - p[1]) + 3 * (p[8] - p[2]);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    t  = thr_cfg;
    res.pixel = window_px[4];
    if (ax >= t || ay >= t || ax * ax + ay * ay >= t * t) res.pixel = '0;
    res.is_last = (r + 1 >= h) && (c + 1 >= w);
    filtered_q.push_back(res);

    if (res.is_last) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else if (c + 1 >= w) begin
      out_col = 0;
      out_row = r + 1;
    end else begin
      out_col = c + 1;
    end
  endfunction

  task automatic send_item(input pix_t px, input logic flush);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= flush;
    do @(posedge clk); while (!in_tready);
    compute_filter_step(px, flush);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (filtered_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRAD_THRESHOLD: thr_cfg    = value[THR_W-1:0];
      CFG_IMAGE_WIDTH:    width_cfg  = value[WID_W-1:0];
      CFG_IMAGE_HEIGHT:   height_cfg = value[HGT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [WID_W-1:0] w,
                           input logic [HGT_W-1:0] h);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(CFG_GRAD_THRESHOLD, thr);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_frame(input pix_style_t style, input bit pause_mid);
    int unsigned w, n, base, amp, flush_pct, junk_pct, pause_at, i, v;
    w = eff_width();
    n = w * ((height_cfg == 0) ? 1 : height_cfg);
    base = (style == PIX_DIM) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
    amp = $urandom_range(0, 31);
    flush_pct = $urandom_range(0, 1) ? 0 : 10;
    junk_pct = $urandom_range(0, 1) ? 0 : 30;
    pause_at = pause_mid ? $urandom_range(0, n - 1) : n;
    for (i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      case (style)
        PIX_NOISE: v = $urandom_range(0, 65535);
        PIX_EXTREME: v = ($urandom_range(0, 2) == 0) ? 0 :
                         ($urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535));
        default: v = base + $urandom_range(0, amp);
      endcase
      if (v > 65535) v = 65535;
      send_item(pix_t'(v), $urandom_range(0, 99) < flush_pct);
    end
    // bottom padding: samples here are masked, so junk must not matter
    for (i = 0; i <= w; i++)
      send_item(pix_t'($urandom), !($urandom_range(0, 99) < junk_pct));
  endtask

  task automatic test_threshold_zero();
    configure(0, 2, 2);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h8000, 1'b1);
    repeat (3) send_item(16'h5A5A, 1'b1);
  endtask

  // gx = 30, gy = 40 on the first pixel: magnitude exactly at the limit
  task automatic test_limit_equality();
    configure(50, 2, 2);
    send_item(16'd9, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd0, 1'b0);
    repeat (3) send_item(16'h0000, 1'b1);
  endtask

  task automatic test_mixed_frame();
    pix_t px [9];
    int   i;
    px = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd3, 16'hBEEF, 16'hFFFF, 16'd7, 16'd8};
    configure(100, 3, 3);
    for (i = 0; i < 9; i++) send_item(px[i], i == 5);
    send_item(16'h1234, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'hAAAA, 1'b1);
  endtask

  task automatic test_size_corners();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    configure(pick_threshold(), 0, 0);
    send_frame(PIX_NOISE, 1'b0);
    configure(pick_threshold(), 1, 5);
    send_frame(PIX_DIM, 1'b0);
    tx_calm = 1'b1;
    configure(pick_threshold(), 48, 1);
    send_frame(PIX_SMOOTH, 1'b0);
    tx_calm = 1'b0;
    configure(pick_threshold(), 1, 40);
    send_frame(PIX_EXTREME, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned start, r, w, h;
    bit          first_frame;
    start = items_sent;
    first_frame = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (first_frame || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        w = (r < 70) ? $urandom_range(1, 8) :
            (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 160);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        // keep one frame small against the item budget
        if (w * h > 400) h = 400 / w;
        configure(pick_threshold(), w, h);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      send_frame(pix_style_t'($urandom_range(0, 3)),
                 first_frame || $urandom_range(0, 7) == 0);
      first_frame = 1'b0;
    end
  endtask

  initial begin : rx_pacing
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin : result_check
    filtered_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        $error("result with nothing outstanding: pixel_out=%0d last_of_frame=%0b",
               out_tdata, out_tlast);
        n_errors++;
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata !== want.pixel) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, out_tdata);
          n_errors++;
        end
        if (out_tlast !== want.is_last) begin
          $error("last_of_frame mismatch: expected %0b, actual %0b", want.is_last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : test_sequence
    int i;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_GRAD_THRESHOLD;
    cfg_data   = '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    items_sent = 0;
    n_errors   = 0;
    quiet_cycles = 0;
    thr_cfg    = '0;
    width_cfg  = WID_W'(WIDTH_RST);
    height_cfg = HGT_W'(HEIGHT_RST);
    for (i = 0; i < MAX_W; i++) begin
      above_line[i]  = '0;
      center_line[i] = '0;
    end
    for (i = 0; i < 9; i++) window_px[i] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_threshold_zero();
    test_limit_equality();
    test_mixed_frame();
    test_size_corners();
    test_random_frames();

    wait_drained();
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
